// ===== rtl/mlfs_pkg.sv =====
// Package for the memory LCD frame serializer.
// Holds the frame geometry defaults, operation and stream phase codes, the
// controller state type, the command/status structs and the line number bit reversal.
`timescale 1ns / 1ps
`default_nettype none

package mlfs_pkg;

    localparam int ROWS_DEF      = 96;
    localparam int ROW_BYTES_DEF = 12;
    localparam int BAND_ROWS_DEF = 24;

    localparam logic [7:0] WRITE_COMMAND_RESET = 8'd128;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_INVERT  = 2'd1,
        OP_REQUEST = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PH_COMMAND = 2'd0,
        PH_LINE    = 2'd1,
        PH_DATA    = 2'd2,
        PH_TRAILER = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_INV_READ,
        ST_INV_WRITE,
        ST_REQ_READ,
        ST_REQ_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic store;
        logic inv_read;
        logic inv_write;
        logic req_read;
        logic req_emit;
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic inv_done;
        logic out_free;
    } t_status;

    function automatic logic [7:0] bit_reverse8(input logic [7:0] v);
        logic [7:0] b;
        b = ((v & 8'hF0) >> 4) | ((v & 8'h0F) << 4);
        b = ((b & 8'hCC) >> 2) | ((b & 8'h33) << 2);
        b = ((b & 8'hAA) >> 1) | ((b & 8'h55) << 1);
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/memory_lcd_frame_serializer_core.sv =====
// Top level of the memory LCD frame serializer.
// Joins the controller mlfs_ctrl and the datapath mlfs_dpath; uses mlfs_pkg.
//
// Channel  Direction  Handshake                 Word
// in       input      i_in_valid / o_in_ready   operation, row, column, data, band
// out      output     o_out_valid / i_out_ready out_byte, first_of_frame, last_of_frame
// cfg      input      i_cfg_valid / o_cfg_ready write command byte
//
// A write passes the idle and write states, a stream request the idle, read and emit states,
// plus any wait for the output register in emit. A band invert reads, then writes back inverted,
// each frame memory byte of the band in turn through its single read and write port.
// After reset a clearing pass writes ROWS * ROW_BYTES zeros, one per cycle, before the
// first input word is taken; configuration writes are taken at all times.
// A new input word is taken while a finished stream word still waits at the output.
`timescale 1ns / 1ps
`default_nettype none

module memory_lcd_frame_serializer_core
    import mlfs_pkg::*;
#(
    parameter int ROWS      = ROWS_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    parameter int BAND_ROWS = BAND_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [1:0] i_operation,
    input  wire logic [6:0] i_row_index,
    input  wire logic [3:0] i_column_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic [1:0] i_band_index,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_first_of_frame,
    output logic            o_last_of_frame,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [7:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    mlfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_status    (status),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    mlfs_dpath #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES),
        .BAND_ROWS (BAND_ROWS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_row_index      (i_row_index),
        .i_column_index   (i_column_index),
        .i_write_data     (i_write_data),
        .i_band_index     (i_band_index),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_data       (i_cfg_data),
        .i_out_ready      (i_out_ready),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .o_out_byte       (o_out_byte),
        .o_first_of_frame (o_first_of_frame),
        .o_last_of_frame  (o_last_of_frame)
    );

endmodule

`default_nettype wire

// ===== rtl/mlfs_ctrl.sv =====
// Controller state machine of the memory LCD frame serializer.
// Sequences clearing, writes, band inversion and stream requests; uses mlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlfs_ctrl
    import mlfs_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_operation,
    input  wire t_status    i_status,
    output logic            o_in_ready,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_operation)
                        OP_WRITE:   n_state = ST_WRITE;
                        OP_INVERT:  n_state = ST_INV_READ;
                        OP_REQUEST: n_state = ST_REQ_READ;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:     n_state = ST_IDLE;
            ST_INV_READ: begin
                n_state = i_status.inv_done ? ST_IDLE : ST_INV_WRITE;
            end
            ST_INV_WRITE: n_state = ST_INV_READ;
            ST_REQ_READ:  n_state = ST_REQ_EMIT;
            ST_REQ_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR:     o_cmd.clear = 1'b1;
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ST_WRITE:     o_cmd.store = 1'b1;
            ST_INV_READ:  o_cmd.inv_read = !i_status.inv_done;
            ST_INV_WRITE: o_cmd.inv_write = 1'b1;
            ST_REQ_READ:  o_cmd.req_read = 1'b1;
            ST_REQ_EMIT:  o_cmd.req_emit = i_status.out_free;
            default: begin
                o_cmd      = '0;
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/mlfs_dpath.sv =====
// Datapath of the memory LCD frame serializer: frame memory, clear and invert
// address counters, stream position, command register and output register; uses mlfs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mlfs_dpath
    import mlfs_pkg::*;
#(
    parameter int ROWS      = ROWS_DEF,
    parameter int ROW_BYTES = ROW_BYTES_DEF,
    parameter int BAND_ROWS = BAND_ROWS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    input  wire logic [6:0] i_row_index,
    input  wire logic [3:0] i_column_index,
    input  wire logic [7:0] i_write_data,
    input  wire logic [1:0] i_band_index,
    input  wire logic       i_cfg_valid,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_out_ready,
    output t_status         o_status,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_first_of_frame,
    output logic            o_last_of_frame
);

    localparam int DEPTH = ROWS * ROW_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW    = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int PW    = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

    logic [7:0]    r_mem [DEPTH];
    logic [7:0]    r_rd_data;

    logic [AW-1:0] r_clr_addr;
    logic [6:0]    r_wr_row;
    logic [3:0]    r_wr_col;
    logic [7:0]    r_wr_data;
    logic [EW-1:0] r_inv_addr;
    logic [EW-1:0] r_inv_end;
    logic [EW-1:0] n_inv_addr;
    logic [EW-1:0] n_inv_end;

    logic [7:0]    r_write_command;
    logic [RW-1:0] r_stream_row;
    logic [PW-1:0] r_stream_pos;
    t_phase        r_stream_phase;
    logic [RW-1:0] n_stream_row;
    logic [PW-1:0] n_stream_pos;
    t_phase        n_stream_phase;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_first;
    logic          r_out_last;
    logic [7:0]    n_out_byte;
    logic          n_out_first;
    logic          n_out_last;

    logic          wr_ok;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] stream_addr;

    assign wr_ok       = (int'(r_wr_row) < ROWS) && (int'(r_wr_col) < ROW_BYTES);
    assign wr_addr     = AW'(int'(r_wr_row) * ROW_BYTES + int'(r_wr_col));
    assign stream_addr = AW'(int'(r_stream_row) * ROW_BYTES + int'(r_stream_pos));

    always_comb begin
        int band_start;
        int band_stop;
        band_start = int'(i_band_index) * BAND_ROWS;
        band_stop  = band_start + BAND_ROWS;
        if (band_stop > ROWS) begin
            band_stop = ROWS;
        end
        if (band_start >= ROWS) begin
            band_start = 0;
            band_stop  = 0;
        end
        n_inv_addr = EW'(band_start * ROW_BYTES);
        n_inv_end  = EW'(band_stop * ROW_BYTES);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = 8'd0;
        if (i_cmd.clear) begin
            mem_we = 1'b1;
        end else if (i_cmd.store) begin
            mem_we    = wr_ok;
            mem_waddr = wr_addr;
            mem_wdata = r_wr_data;
        end else if (i_cmd.inv_write) begin
            mem_we    = 1'b1;
            mem_waddr = r_inv_addr[AW-1:0];
            mem_wdata = ~r_rd_data;
        end
        mem_re    = i_cmd.inv_read | i_cmd.req_read;
        mem_raddr = i_cmd.inv_read ? r_inv_addr[AW-1:0] : stream_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_wr_row   <= i_row_index;
            r_wr_col   <= i_column_index;
            r_wr_data  <= i_write_data;
            r_inv_addr <= n_inv_addr;
            r_inv_end  <= n_inv_end;
        end else if (i_cmd.inv_write) begin
            r_inv_addr <= r_inv_addr + EW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_command <= WRITE_COMMAND_RESET;
        end else if (i_cfg_valid) begin
            r_write_command <= i_cfg_data;
        end
    end

    always_comb begin
        n_stream_row   = r_stream_row;
        n_stream_pos   = r_stream_pos;
        n_stream_phase = r_stream_phase;
        n_out_byte     = 8'd0;
        n_out_first    = 1'b0;
        n_out_last     = 1'b0;
        case (r_stream_phase)
            PH_COMMAND: begin
                n_out_byte     = r_write_command;
                n_out_first    = 1'b1;
                n_stream_row   = '0;
                n_stream_pos   = '0;
                n_stream_phase = PH_LINE;
            end
            PH_LINE: begin
                if (r_stream_row == RW'(ROWS)) begin
                    n_out_last     = 1'b1;
                    n_stream_row   = '0;
                    n_stream_pos   = '0;
                    n_stream_phase = PH_COMMAND;
                end else begin
                    n_out_byte     = bit_reverse8(8'(r_stream_row) + 8'd1);
                    n_stream_pos   = '0;
                    n_stream_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                n_out_byte = r_rd_data;
                if (r_stream_pos == PW'(ROW_BYTES - 1)) begin
                    n_stream_pos   = '0;
                    n_stream_phase = PH_TRAILER;
                end else begin
                    n_stream_pos = r_stream_pos + PW'(1);
                end
            end
            PH_TRAILER: begin
                n_stream_row   = r_stream_row + RW'(1);
                n_stream_pos   = '0;
                n_stream_phase = PH_LINE;
            end
            default: begin
                n_stream_phase = PH_COMMAND;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_row   <= '0;
            r_stream_pos   <= '0;
            r_stream_phase <= PH_COMMAND;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.req_emit) begin
                r_stream_row   <= n_stream_row;
                r_stream_pos   <= n_stream_pos;
                r_stream_phase <= n_stream_phase;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.req_emit) begin
            r_out_byte  <= n_out_byte;
            r_out_first <= n_out_first;
            r_out_last  <= n_out_last;
        end
    end

    assign o_status.clear_done = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.inv_done   = (r_inv_addr >= r_inv_end);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid      = r_out_valid;
    assign o_out_byte       = r_out_byte;
    assign o_first_of_frame = r_out_first;
    assign o_last_of_frame  = r_out_last;

    a_one_writer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.clear, i_cmd.store, i_cmd.inv_write}))
        else $error("More than one source drives the frame memory write port.");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.req_emit |-> (!r_out_valid || i_out_ready))
        else $error("A stream word overwrote one that was not yet taken.");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.req_emit |=> r_out_valid)
        else $error("An emitted stream word did not show as valid.");

    a_stream_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_stream_row) <= ROWS) && (int'(r_stream_pos) < ROW_BYTES))
        else $error("The stream position left the frame.");

endmodule

`default_nettype wire

// ===== dv/tb_memory_lcd_frame_serializer_core.sv =====
// Self-checking testbench for memory_lcd_frame_serializer_core.
// Drives frame edits and stream requests, mirrors the frame store and the stream position,
// and checks every stream byte; depends on mlfs_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_memory_lcd_frame_serializer_core;
    import mlfs_pkg::*;

    localparam int N_ROWS        = ROWS_DEF;
    localparam int N_ROW_BYTES   = ROW_BYTES_DEF;
    localparam int N_BAND_ROWS   = BAND_ROWS_DEF;
    localparam int INVERT_CYCLES = 2 * N_BAND_ROWS * N_ROW_BYTES + 40;
    localparam int HOLD_CYCLES   = 3000;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int PHASE_WORDS   = 350;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [1:0] op;
        logic [6:0] row;
        logic [3:0] col;
        logic [7:0] data;
        logic [1:0] band;
    } t_lcd_word;

    typedef struct {
        logic [7:0] pix;
        logic       is_first;
        logic       is_last;
    } t_stream_byte;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [1:0] i_operation    = 2'd0;
    logic [6:0] i_row_index    = 7'd0;
    logic [3:0] i_column_index = 4'd0;
    logic [7:0] i_write_data   = 8'd0;
    logic [1:0] i_band_index   = 2'd0;
    logic       i_out_ready    = 1'b0;
    logic       i_cfg_valid    = 1'b0;
    logic [7:0] i_cfg_data     = 8'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_first_of_frame;
    logic       o_last_of_frame;
    logic       o_cfg_ready;

    t_lcd_word    pending_words[$];
    t_stream_byte stream_bytes_due[$];
    t_lcd_word    cur_word;

    logic [7:0]  frame_mirror [N_ROWS][N_ROW_BYTES];
    int unsigned scan_row   = 0;
    int unsigned scan_col   = 0;
    t_phase      scan_phase = PH_COMMAND;
    logic [7:0]  cmd_byte   = WRITE_COMMAND_RESET;

    int n_words_queued = 0;
    int n_words_sent   = 0;
    int n_bytes_seen   = 0;
    int n_frames_seen  = 0;
    int n_errors       = 0;
    int n_cycles       = 0;
    int idle_pct       = 30;
    int send_gap       = 0;
    int recv_gap       = 0;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;

    memory_lcd_frame_serializer_core DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_row_index      (i_row_index),
        .i_column_index   (i_column_index),
        .i_write_data     (i_write_data),
        .i_band_index     (i_band_index),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_first_of_frame (o_first_of_frame),
        .o_last_of_frame  (o_last_of_frame),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(60, 10);
        return $urandom_range(3, 1);
    endfunction

    // Applies one accepted word to the mirrored frame and stream position.
    function automatic void panel_apply(input t_lcd_word w);
        t_stream_byte nb;
        logic [7:0]   line;
        int           r;
        int           c;
        nb.pix      = 8'h00;
        nb.is_first = 1'b0;
        nb.is_last  = 1'b0;
        case (w.op)
            OP_WRITE: begin
                if (w.row < N_ROWS && w.col < N_ROW_BYTES)
                    frame_mirror[w.row][w.col] = w.data;
            end
            OP_INVERT: begin
                for (r = int'(w.band) * N_BAND_ROWS;
                     r < (int'(w.band) + 1) * N_BAND_ROWS && r < N_ROWS; r++)
                    for (c = 0; c < N_ROW_BYTES; c++)
                        frame_mirror[r][c] = ~frame_mirror[r][c];
            end
            OP_REQUEST: begin
                case (scan_phase)
                    PH_COMMAND: begin
                        nb.pix      = cmd_byte;
                        nb.is_first = 1'b1;
                        scan_row    = 0;
                        scan_col    = 0;
                        scan_phase  = PH_LINE;
                    end
                    PH_LINE: begin
                        if (scan_row >= N_ROWS) begin
                            nb.is_last = 1'b1;
                            scan_row   = 0;
                            scan_col   = 0;
                            scan_phase = PH_COMMAND;
                        end else begin
                            line = 8'(scan_row + 1);
                            for (c = 0; c < 8; c++)
                                nb.pix[c] = line[7 - c];
                            scan_col   = 0;
                            scan_phase = PH_DATA;
                        end
                    end
                    PH_DATA: begin
                        nb.pix = frame_mirror[scan_row][scan_col];
                        scan_col++;
                        if (scan_col >= N_ROW_BYTES) begin
                            scan_col   = 0;
                            scan_phase = PH_TRAILER;
                        end
                    end
                    default: begin
                        scan_row++;
                        scan_col   = 0;
                        scan_phase = PH_LINE;
                    end
                endcase
                stream_bytes_due.push_back(nb);
            end
            default: ;
        endcase
    endfunction

    task automatic queue_word(input logic [1:0] op, input logic [6:0] row,
                              input logic [3:0] col, input logic [7:0] data,
                              input logic [1:0] band);
        t_lcd_word w;
        w.op   = op;
        w.row  = row;
        w.col  = col;
        w.data = data;
        w.band = band;
        pending_words.push_back(w);
        n_words_queued++;
    endtask

    task automatic set_command(input logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cmd_byte = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (n_words_sent != n_words_queued || stream_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (INVERT_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : drive_words
        logic offering;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                panel_apply(cur_word);
                n_words_sent++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    cur_word = pending_words.pop_front();
                    i_operation    <= cur_word.op;
                    i_row_index    <= cur_word.row;
                    i_column_index <= cur_word.col;
                    i_write_data   <= cur_word.data;
                    i_band_index   <= cur_word.band;
                    i_in_valid     <= 1'b1;
                    send_gap = pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_bytes
        t_stream_byte due;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_bytes_seen++;
                if (o_last_of_frame) n_frames_seen++;
                if (stream_bytes_due.size() == 0) begin
                    $display("%0t: unexpected stream byte, expected none, actual %h",
                             $time, o_out_byte);
                    n_errors++;
                end else begin
                    due = stream_bytes_due.pop_front();
                    if (o_out_byte !== due.pix) begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, due.pix, o_out_byte);
                        n_errors++;
                    end
                    if (o_first_of_frame !== due.is_first) begin
                        $display("%0t: first_of_frame expected %b actual %b",
                                 $time, due.is_first, o_first_of_frame);
                        n_errors++;
                    end
                    if (o_last_of_frame !== due.is_last) begin
                        $display("%0t: last_of_frame expected %b actual %b",
                                 $time, due.is_last, o_last_of_frame);
                        n_errors++;
                    end
                end
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int r;
        int c;
        int k;
        int pick;
        logic [1:0] op;
        for (r = 0; r < N_ROWS; r++)
            for (c = 0; c < N_ROW_BYTES; c++)
                frame_mirror[r][c] = 8'h00;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Edits land mid-frame, before their bytes are streamed.
        queue_word(OP_REQUEST, 7'd0, 4'd0, 8'h00, 2'd0);
        queue_word(OP_REQUEST, 7'd0, 4'd0, 8'h00, 2'd0);
        queue_word(OP_WRITE, 7'd0, 4'd0, 8'hFF, 2'd0);
        queue_word(OP_WRITE, 7'd0, 4'd11, 8'h81, 2'd0);
        queue_word(OP_WRITE, 7'd95, 4'd11, 8'hA5, 2'd0);
        queue_word(OP_WRITE, 7'd96, 4'd0, 8'h5A, 2'd0);
        queue_word(OP_WRITE, 7'd127, 4'd15, 8'hFF, 2'd3);
        queue_word(OP_WRITE, 7'd0, 4'd12, 8'h3C, 2'd0);
        queue_word(OP_WRITE, 7'd5, 4'd15, 8'h77, 2'd0);
        queue_word(OP_INVERT, 7'd0, 4'd0, 8'h00, 2'd3);
        queue_word(OP_INVERT, 7'd127, 4'd15, 8'hFF, 2'd0);
        queue_word(OP_UNUSED, 7'd127, 4'd15, 8'hFF, 2'd3);
        queue_word(OP_UNUSED, 7'd0, 4'd0, 8'h00, 2'd0);
        repeat (4) queue_word(OP_REQUEST, 7'd0, 4'd0, 8'h00, 2'd0);
        queue_word(OP_INVERT, 7'd0, 4'd0, 8'h00, 2'd1);
        queue_word(OP_INVERT, 7'd0, 4'd0, 8'h00, 2'd2);
        queue_word(OP_WRITE, 7'd64, 4'd3, 8'h00, 2'd0);
        repeat (3) queue_word(OP_REQUEST, 7'd127, 4'd15, 8'hFF, 2'd3);
        settle();

        k = 0;
        while (n_words_queued < 1400) begin
            if (k == 0) set_command(8'h00);
            else if (k == 1) set_command(8'hFF);
            else set_command(8'($urandom_range(255)));
            idle_pct = (k == 1) ? 0 : (k == 2) ? 40 : 25;
            if (k == 2) hold_requests++;
            repeat (PHASE_WORDS) begin
                pick = $urandom_range(99);
                op = (pick < 78) ? OP_REQUEST : (pick < 94) ? OP_WRITE :
                     (pick < 97) ? OP_INVERT : OP_UNUSED;
                queue_word(op,
                           ($urandom_range(99) < 85) ? 7'($urandom_range(N_ROWS - 1))
                                                     : 7'($urandom_range(127)),
                           ($urandom_range(99) < 85) ? 4'($urandom_range(N_ROW_BYTES - 1))
                                                     : 4'($urandom_range(15)),
                           8'($urandom_range(255)),
                           2'($urandom_range(3)));
            end
            settle();
            k++;
        end

        $display("Sent %0d words in %0d phases; checked %0d stream bytes over %0d frame ends.",
                 n_words_sent, k + 1, n_bytes_seen, n_frames_seen);
        if (n_errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== memory_lcd_frame_serializer_core.f =====
rtl/mlfs_pkg.sv
rtl/mlfs_ctrl.sv
rtl/mlfs_dpath.sv
rtl/memory_lcd_frame_serializer_core.sv
dv/tb_memory_lcd_frame_serializer_core.sv
